FILE: hw/rtl/aff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aff_pkg
// Shared types and constants for the affine 2x3 matrix inverse.
// ----------------------------------------------------------------------------
package aff_pkg;

  // Fractional bits of the coefficient format (Q16.16 by default)
  localparam int FRAC_BITS = 16;

  // Saturation rails of the 32-bit signed result
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
    logic signed [31:0] coef_e;
    logic signed [31:0] coef_f;
  } item_t;

  typedef struct packed {
    logic signed [31:0] inv_a;
    logic signed [31:0] inv_b;
    logic signed [31:0] inv_c;
    logic signed [31:0] inv_d;
    logic signed [31:0] inv_e;
    logic signed [31:0] inv_f;
    logic               invertible;
    logic               saturated;
  } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/affine_2d_matrix_inverse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// affine_2d_matrix_inverse
// Inverts a 2x3 affine matrix [a b c; d e f] in signed fixed point.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+-------------------
//   item     | in        | item_valid / item_ready     | aff_pkg::item_t
//   result   | out       | result_valid / result_ready | aff_pkg::result_t
//
// One transaction enters per cycle unless the output stalls. The depth grows
// with FRAC_BITS (Q16.16 default), one quotient bit per reciprocal stage.
// All stages advance together; while a finished result is held at the output
// and not taken, the pipeline holds and item_ready is low.
// Reset clears the valid bits only; payload registers are not reset.
//
module affine_2d_matrix_inverse #(
  parameter int FRAC_BITS = aff_pkg::FRAC_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire aff_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output aff_pkg::result_t      result
);

  // Quotient width and divider depth: floor(2^(2F+32) / |det|)
  localparam int QW  = 2 * FRAC_BITS + 33;
  localparam int NBQ = (QW + 31) / 32;
  localparam int PWS = 32 * (1 + NBQ);
  localparam int PWT = 32 * (2 + NBQ);
  localparam int SHT = FRAC_BITS + 32;

  typedef struct packed {
    logic [31:0] mag_a;   // |e|
    logic [31:0] mag_b;   // |b|
    logic [63:0] mag_c;   // |b*f - e*c|
    logic [31:0] mag_d;   // |d|
    logic [31:0] mag_e;   // |a|
    logic [63:0] mag_f;   // |d*c - a*f|
    logic [5:0]  neg;     // result sign per lane
    logic        sing;    // determinant is zero
  } pass_t;

  typedef struct packed {
    logic [62:0]   den;
    logic [62:0]   rem;
    logic [QW-1:0] q;
  } div_t;

  logic en;

  // Stage 1: raw products
  logic               v1;
  logic signed [31:0] s1_a, s1_b, s1_d, s1_e;
  logic signed [63:0] p_ae, p_bd, p_bf, p_ec, p_dc, p_af;

  // Stage 2 and divider stages
  logic               dv [QW+1];
  div_t               dd [QW+1];
  pass_t              dp [QW+1];
  logic signed [63:0] det, tx, ty;
  logic [63:0]        det_mag;
  pass_t              s2_pass;

  logic [63:0]        rem2 [QW];
  logic               ge   [QW];
  logic [62:0]        nrem [QW];

  // Multiplier stages
  logic               mv   [3];
  logic [5:0]         mneg [3];
  logic               msing[3];
  logic [PWS-1:0]     prod_a, prod_b, prod_d, prod_e;
  logic [PWT-1:0]     prod_c, prod_f;

  logic [31:0]        lane_mag [6];
  logic               lane_big [6];
  logic [31:0]        lane_val [6];
  logic               lane_sat [6];
  logic               any_sat;

  // Advance everything when the output slot is free or being emptied
  assign en         = !result_valid || result_ready;
  assign item_ready = en;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a <= item.coef_a;
      s1_b <= item.coef_b;
      s1_d <= item.coef_d;
      s1_e <= item.coef_e;
      p_ae <= 64'(item.coef_a) * 64'(item.coef_e);
      p_bd <= 64'(item.coef_b) * 64'(item.coef_d);
      p_bf <= 64'(item.coef_b) * 64'(item.coef_f);
      p_ec <= 64'(item.coef_e) * 64'(item.coef_c);
      p_dc <= 64'(item.coef_d) * 64'(item.coef_c);
      p_af <= 64'(item.coef_a) * 64'(item.coef_f);
    end
  end

  // Determinant and translation cofactors; signs fold in the determinant sign
  always_comb begin
    det     = p_ae - p_bd;
    tx      = p_bf - p_ec;
    ty      = p_dc - p_af;
    det_mag = det[63] ? 64'(0) - det : det;

    s2_pass.mag_a  = s1_e[31] ? 32'(0) - s1_e : s1_e;
    s2_pass.mag_b  = s1_b[31] ? 32'(0) - s1_b : s1_b;
    s2_pass.mag_c  = tx[63] ? 64'(0) - tx : tx;
    s2_pass.mag_d  = s1_d[31] ? 32'(0) - s1_d : s1_d;
    s2_pass.mag_e  = s1_a[31] ? 32'(0) - s1_a : s1_a;
    s2_pass.mag_f  = ty[63] ? 64'(0) - ty : ty;
    s2_pass.neg[0] = s1_e[31] ^ det[63];
    s2_pass.neg[1] = (!s1_b[31] && (s1_b != 32'sd0)) ^ det[63];
    s2_pass.neg[2] = tx[63] ^ det[63];
    s2_pass.neg[3] = (!s1_d[31] && (s1_d != 32'sd0)) ^ det[63];
    s2_pass.neg[4] = s1_a[31] ^ det[63];
    s2_pass.neg[5] = ty[63] ^ det[63];
    s2_pass.sing   = (det == 64'sd0);
  end

  // Restoring division, one quotient bit per stage; numerator is a single one
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      rem2[k] = {dd[k].rem, (k == 0)};
      ge[k]   = rem2[k] >= {1'b0, dd[k].den};
      nrem[k] = ge[k] ? 63'(rem2[k] - {1'b0, dd[k].den}) : rem2[k][62:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0].den <= det_mag[62:0];
      dd[0].rem <= '0;
      dd[0].q   <= '0;
      dp[0]     <= s2_pass;
      for (int k = 0; k < QW; k++) begin
        dd[k+1].den <= dd[k].den;
        dd[k+1].rem <= nrem[k];
        dd[k+1].q   <= {dd[k].q[QW-2:0], ge[k]};
        dp[k+1]     <= dp[k];
      end
      mneg[0]  <= dp[QW].neg;
      msing[0] <= dp[QW].sing;
      for (int k = 1; k < 3; k++) begin
        mneg[k]  <= mneg[k-1];
        msing[k] <= msing[k-1];
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      result_valid <= 1'b0;
      for (int k = 0; k <= QW; k++) dv[k] <= 1'b0;
      for (int k = 0; k < 3; k++)   mv[k] <= 1'b0;
    end else if (en) begin
      v1    <= item_valid;
      dv[0] <= v1;
      for (int k = 0; k < QW; k++) dv[k+1] <= dv[k];
      mv[0] <= dv[QW];
      for (int k = 1; k < 3; k++) mv[k] <= mv[k-1];
      result_valid <= mv[2];
    end
  end

  // Cofactor magnitude times reciprocal
  aff_mul #(.AW(32), .BW(QW)) u_mul_a (
    .clk(clk), .en(en), .a(dp[QW].mag_a), .b(dd[QW].q), .p(prod_a));
  aff_mul #(.AW(32), .BW(QW)) u_mul_b (
    .clk(clk), .en(en), .a(dp[QW].mag_b), .b(dd[QW].q), .p(prod_b));
  aff_mul #(.AW(64), .BW(QW)) u_mul_c (
    .clk(clk), .en(en), .a(dp[QW].mag_c), .b(dd[QW].q), .p(prod_c));
  aff_mul #(.AW(32), .BW(QW)) u_mul_d (
    .clk(clk), .en(en), .a(dp[QW].mag_d), .b(dd[QW].q), .p(prod_d));
  aff_mul #(.AW(32), .BW(QW)) u_mul_e (
    .clk(clk), .en(en), .a(dp[QW].mag_e), .b(dd[QW].q), .p(prod_e));
  aff_mul #(.AW(64), .BW(QW)) u_mul_f (
    .clk(clk), .en(en), .a(dp[QW].mag_f), .b(dd[QW].q), .p(prod_f));

  // Drop the fraction, then clip and apply the sign; a singular matrix gives zeros
  always_comb begin
    lane_mag[0] = prod_a[32 +: 32];  lane_big[0] = |prod_a[PWS-1:64];
    lane_mag[1] = prod_b[32 +: 32];  lane_big[1] = |prod_b[PWS-1:64];
    lane_mag[2] = prod_c[SHT +: 32]; lane_big[2] = |prod_c[PWT-1:SHT+32];
    lane_mag[3] = prod_d[32 +: 32];  lane_big[3] = |prod_d[PWS-1:64];
    lane_mag[4] = prod_e[32 +: 32];  lane_big[4] = |prod_e[PWS-1:64];
    lane_mag[5] = prod_f[SHT +: 32]; lane_big[5] = |prod_f[PWT-1:SHT+32];
    any_sat = 1'b0;
    for (int k = 0; k < 6; k++) begin
      lane_sat[k] = 1'b0;
      if (msing[2]) begin
        lane_val[k] = '0;
      end else if (mneg[2][k]) begin
        if (lane_big[k] || (lane_mag[k] > aff_pkg::SAT_NEG)) begin
          lane_val[k] = aff_pkg::SAT_NEG;
          lane_sat[k] = 1'b1;
        end else begin
          lane_val[k] = 32'(0) - lane_mag[k];
        end
      end else begin
        if (lane_big[k] || lane_mag[k][31]) begin
          lane_val[k] = aff_pkg::SAT_POS;
          lane_sat[k] = 1'b1;
        end else begin
          lane_val[k] = lane_mag[k];
        end
      end
      any_sat = any_sat | lane_sat[k];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      result.inv_a      <= lane_val[0];
      result.inv_b      <= lane_val[1];
      result.inv_c      <= lane_val[2];
      result.inv_d      <= lane_val[3];
      result.inv_e      <= lane_val[4];
      result.inv_f      <= lane_val[5];
      result.invertible <= !msing[2];
      result.saturated  <= any_sat;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/aff_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aff_mul
// Unsigned AW x BW multiplier built from 32x32 partial products, three stages.
// ----------------------------------------------------------------------------
module aff_mul #(
  parameter int AW = 32,
  parameter int BW = 65
) (
  input  wire logic                                          clk,
  input  wire logic                                          en,
  input  wire logic [AW-1:0]                                 a,
  input  wire logic [BW-1:0]                                 b,
  output logic [32*(((AW+31)/32)+((BW+31)/32))-1:0]          p
);

  localparam int NA = (AW + 31) / 32;
  localparam int NB = (BW + 31) / 32;
  localparam int RW = 32 * (NB + 1);
  localparam int PW = 32 * (NA + NB);

  logic [32*NA-1:0] ax;
  logic [32*NB-1:0] bx;
  logic [63:0]      pp  [NA][NB];
  logic [RW-1:0]    ev  [NA];
  logic [RW-1:0]    od  [NA];
  logic [RW-1:0]    row [NA];
  logic [PW-1:0]    sum;

  assign ax = (32*NA)'(a);
  assign bx = (32*NB)'(b);

  // Partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= 64'(ax[32*i +: 32]) * 64'(bx[32*j +: 32]);
        end
      end
    end
  end

  // Even and odd columns do not overlap: one add per row
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      ev[i] = '0;
      od[i] = '0;
      for (int j = 0; j < NB; j++) begin
        if (j % 2 == 0) ev[i][32*j +: 64] = pp[i][j];
        else            od[i][32*j +: 64] = pp[i][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) row[i] <= ev[i] + od[i];
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) sum = sum + (PW'(row[i]) << (32 * i));
  end

  always_ff @(posedge clk) begin
    if (en) p <= sum;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/aff_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aff_checker
// Port-level assertions for the affine matrix inverse, bound to the top level.
// ----------------------------------------------------------------------------
module aff_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_ready,
  input wire logic             result_valid,
  input wire logic             result_ready,
  input wire aff_pkg::result_t result
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Stall the input side while a result waits
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !item_ready)
    else $error("input taken while output stalled");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_singular: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.invertible |->
      result.inv_a == 32'sd0 && result.inv_b == 32'sd0 && result.inv_c == 32'sd0 &&
      result.inv_d == 32'sd0 && result.inv_e == 32'sd0 && result.inv_f == 32'sd0 &&
      !result.saturated)
    else $error("singular result not cleared");

  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |->
      result.inv_a == aff_pkg::SAT_POS || result.inv_a == aff_pkg::SAT_NEG ||
      result.inv_b == aff_pkg::SAT_POS || result.inv_b == aff_pkg::SAT_NEG ||
      result.inv_c == aff_pkg::SAT_POS || result.inv_c == aff_pkg::SAT_NEG ||
      result.inv_d == aff_pkg::SAT_POS || result.inv_d == aff_pkg::SAT_NEG ||
      result.inv_e == aff_pkg::SAT_POS || result.inv_e == aff_pkg::SAT_NEG ||
      result.inv_f == aff_pkg::SAT_POS || result.inv_f == aff_pkg::SAT_NEG)
    else $error("saturated flag without a clipped output");

endmodule

bind affine_2d_matrix_inverse aff_checker u_aff_checker (.*);
`default_nettype wire
